>>> hdl/vbr_pkg.sv
// ----------------------------------------------------------------------------
// vbr_pkg
// Shared types and constants for the Voigt basis rotation core.
// ----------------------------------------------------------------------------
package vbr_pkg;

  localparam int VDIM      = 6;
  localparam int NCOEF     = VDIM * VDIM;
  localparam int RND_SHIFT = 20;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_STRAIN_FWD = 3'd1,
    OP_STRESS_BWD = 3'd2,
    OP_STRESS_FWD = 3'd3,
    OP_STRAIN_BWD = 3'd4
  } vbr_op_t;

  typedef logic signed [23:0] coef_t;   // Q3.20
  typedef logic signed [31:0] vec_t;    // Q15.16
  typedef logic signed [56:0] prod_t;   // Q.36 product, doubled if needed
  typedef logic signed [57:0] pair_t;   // sum of two products
  typedef logic signed [60:0] acc_t;    // sum of six products plus round
  typedef logic signed [40:0] rnd_t;    // rounded to Q24.16, before clip to Q15.16

  // One rotation item after coefficient selection.
  typedef struct packed {
    coef_t [NCOEF-1:0] coef;            // already transposed as the mode needs
    vec_t  [VDIM-1:0]  vec;
    logic              strain;
  } vbr_item_t;

endpackage

>>> hdl/vbr_coef_bank.sv
// ----------------------------------------------------------------------------
// vbr_coef_bank
// 6x6 coefficient store with single-entry writes and a transpose select.
// ----------------------------------------------------------------------------
module vbr_coef_bank
  import vbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_row,
  input  logic [2:0]        wr_col,
  input  coef_t             wr_value,
  input  logic              transposed,
  output coef_t [NCOEF-1:0] sel_coef
);

  coef_t [NCOEF-1:0] mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (wr_en) begin
      mat_r[6'(wr_row) * 6'(VDIM) + 6'(wr_col)] <= wr_value;
    end
  end

  // Entry (i,j) of the effective matrix.
  for (genvar i = 0; i < VDIM; i++) begin : g_row
    for (genvar j = 0; j < VDIM; j++) begin : g_col
      assign sel_coef[i*VDIM+j] = transposed ? mat_r[j*VDIM+i] : mat_r[i*VDIM+j];
    end
  end

endmodule

>>> hdl/vbr_dot_pipe.sv
// ----------------------------------------------------------------------------
// vbr_dot_pipe
// Six parallel 6-term dot products: multiply, pair add, final add and round.
// ----------------------------------------------------------------------------
module vbr_dot_pipe
  import vbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vbr_item_t        in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output rnd_t [VDIM-1:0]  out_rnd
);

  logic                    v2_r, v3_r, v4_r;
  logic                    en2, en3, en4;
  prod_t [NCOEF-1:0]       prod_r;
  pair_t [VDIM*3-1:0]      pair_r;
  rnd_t  [VDIM-1:0]        rnd_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign in_ready = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en2) v2_r <= in_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Multiply; double the shear quadrant of the mode.
  for (genvar i = 0; i < VDIM; i++) begin : g_mi
    for (genvar j = 0; j < VDIM; j++) begin : g_mj
      logic signed [55:0] p;
      logic               dbl;
      assign p   = in_item.coef[i*VDIM+j] * in_item.vec[j];
      assign dbl = in_item.strain ? (i >= 3 && j < 3) : (i < 3 && j >= 3);
      always_ff @(posedge clk) begin
        if (en2) prod_r[i*VDIM+j] <= dbl ? {p, 1'b0} : {p[55], p};
      end
    end
  end

  // Pair adds, then three-term add with the rounding constant.
  for (genvar i = 0; i < VDIM; i++) begin : g_ai
    acc_t acc;
    for (genvar k = 0; k < 3; k++) begin : g_pk
      always_ff @(posedge clk) begin
        if (en3) begin
          pair_r[i*3+k] <= pair_t'(prod_r[i*VDIM+2*k]) + pair_t'(prod_r[i*VDIM+2*k+1]);
        end
      end
    end
    assign acc = acc_t'(pair_r[i*3]) + acc_t'(pair_r[i*3+1]) + acc_t'(pair_r[i*3+2])
               + (acc_t'(1) <<< (RND_SHIFT - 1));
    always_ff @(posedge clk) begin
      if (en4) rnd_r[i] <= rnd_t'(acc >>> RND_SHIFT);
    end
  end

  assign out_valid = v4_r;
  assign out_rnd   = rnd_r;

endmodule

>>> hdl/voigt_basis_rotation_3d_core.sv
// ----------------------------------------------------------------------------
// voigt_basis_rotation_3d_core
// Rotates a six-component Voigt tensor by a loadable 6x6 coefficient matrix.
// ----------------------------------------------------------------------------
// A load item (tuser op = load) writes one Q3.20 coefficient and yields no
// result; rows or columns of 6 and 7, and unknown ops, are dropped. A rotation
// item multiplies its Q15.16 vector by the matrix or its transpose, doubles
// the mode's shear quadrant, rounds half up to Q15.16 and clips to 32 bits.
// The core takes one item per cycle when not stalled; a rotation's result passes
// through the selection register, multiplier bank, pair adders, final add and
// round, clip and output register, each stage holding under back-pressure. A load
// takes effect for every item accepted after it.
// ----------------------------------------------------------------------------
module voigt_basis_rotation_3d_core
  import vbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] coef_row, [5:3] coef_col, [29:6] coef_value, [61:30] vec_xx,
  // [93:62] vec_yy, [125:94] vec_zz, [157:126] vec_xy, [189:158] vec_xz,
  // [221:190] vec_yz, [223:222] zero
  input  logic [223:0] in_tdata,
  // [2:0] op
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] res_xx, [63:32] res_yy, [95:64] res_zz, [127:96] res_xy,
  // [159:128] res_xz, [191:160] res_yz
  output logic [191:0] out_tdata,
  // [0] saturated
  output logic [0:0]   out_tuser
);

  vbr_op_t           op;
  logic              accept, is_rot, load_ok, en1;
  logic              s1_valid_r;
  vbr_item_t         s1_item_r, s1_item_nxt;
  coef_t [NCOEF-1:0] sel_coef;
  logic              pipe_ready, pipe_valid;
  rnd_t  [VDIM-1:0]  pipe_rnd;
  logic              out_valid_r, en_out;
  logic [191:0]      out_data_r, out_data_nxt;
  logic              sat_r, sat_nxt;

  assign op        = vbr_op_t'(in_tuser);
  assign en1       = !s1_valid_r || pipe_ready;
  assign in_tready = en1;
  assign accept    = in_tvalid && en1;
  assign is_rot    = (op == OP_STRAIN_FWD) || (op == OP_STRESS_BWD) ||
                     (op == OP_STRESS_FWD) || (op == OP_STRAIN_BWD);
  // Drop loads outside the 6x6 matrix.
  assign load_ok   = (op == OP_LOAD) && (in_tdata[2:0] < 3'(VDIM)) &&
                     (in_tdata[5:3] < 3'(VDIM));

  vbr_coef_bank u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept && load_ok),
    .wr_row     (in_tdata[2:0]),
    .wr_col     (in_tdata[5:3]),
    .wr_value   (coef_t'(in_tdata[29:6])),
    .transposed ((op == OP_STRESS_BWD) || (op == OP_STRAIN_BWD)),
    .sel_coef   (sel_coef)
  );

  always_comb begin
    s1_item_nxt.coef   = sel_coef;
    s1_item_nxt.strain = (op == OP_STRAIN_FWD) || (op == OP_STRAIN_BWD);
    for (int j = 0; j < VDIM; j++) begin
      s1_item_nxt.vec[j] = vec_t'(in_tdata[30 + 32*j +: 32]);
    end
  end

  // Stage 1: selected coefficients and vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= accept && is_rot;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_item_r <= s1_item_nxt;
  end

  vbr_dot_pipe u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (pipe_ready),
    .in_item   (s1_item_r),
    .out_valid (pipe_valid),
    .out_ready (en_out),
    .out_rnd   (pipe_rnd)
  );

  // Clip each component to 32 bits and flag any clip.
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < VDIM; i++) begin
      if (pipe_rnd[i] > rnd_t'(32'sh7fffffff)) begin
        out_data_nxt[32*i +: 32] = 32'h7fffffff;
        sat_nxt = 1'b1;
      end else if (pipe_rnd[i] < -rnd_t'(33'sh080000000)) begin
        out_data_nxt[32*i +: 32] = 32'h80000000;
        sat_nxt = 1'b1;
      end else begin
        out_data_nxt[32*i +: 32] = pipe_rnd[i][31:0];
      end
    end
  end

  // Output register; hold while the sink stalls.
  assign en_out = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
      sat_r      <= sat_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = sat_r;

endmodule

>>> hdl/vbr_checker.sv
// ----------------------------------------------------------------------------
// vbr_checker
// Port-level checks for the Voigt basis rotation core.
// ----------------------------------------------------------------------------
module vbr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [0:0]   out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[31:0] == 32'h7fffffff || out_tdata[31:0] == 32'h80000000 ||
      out_tdata[63:32] == 32'h7fffffff || out_tdata[63:32] == 32'h80000000 ||
      out_tdata[95:64] == 32'h7fffffff || out_tdata[95:64] == 32'h80000000 ||
      out_tdata[127:96] == 32'h7fffffff || out_tdata[127:96] == 32'h80000000 ||
      out_tdata[159:128] == 32'h7fffffff || out_tdata[159:128] == 32'h80000000 ||
      out_tdata[191:160] == 32'h7fffffff || out_tdata[191:160] == 32'h80000000)
    else $error("saturation flag without a clipped component");

endmodule

bind voigt_basis_rotation_3d_core vbr_checker u_vbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Voigt basis rotation core: loads coefficient
// matrices, streams rotation items in all four modes under random idling and
// back-pressure, and compares every result against a local rotation model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import vbr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]   op;
    logic [223:0] data;
  } stim_t;

  typedef struct {
    logic [191:0] res;
    logic         sat;
  } rot_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;

  stim_t       pending_items[$];
  rot_result_t expected_rotations[$];
  coef_t       model_matrix[NCOEF];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          stim_done = 0;
  bit          hold_off_req = 0;

  voigt_basis_rotation_3d_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Apply one accepted item to the model; push the expected rotation, if any.
  function automatic void predict_rotation(stim_t it);
    logic [2:0]   r;
    logic [2:0]   c;
    logic signed [63:0] v[VDIM];
    logic signed [63:0] acc;
    logic signed [63:0] p;
    logic signed [63:0] cf;
    logic signed [63:0] q;
    bit           trans;
    bit           strn;
    bit           dbl;
    rot_result_t  rr;
    r = it.data[2:0];
    c = it.data[5:3];
    if (it.op == OP_LOAD) begin
      if (r < VDIM && c < VDIM) model_matrix[r*VDIM + c] = it.data[29:6];
      return;
    end
    if (it.op > OP_STRAIN_BWD) return;
    trans = (it.op == OP_STRESS_BWD || it.op == OP_STRAIN_BWD);
    strn  = (it.op == OP_STRAIN_FWD || it.op == OP_STRAIN_BWD);
    for (int j = 0; j < VDIM; j++) v[j] = $signed(it.data[30 + 32*j +: 32]);
    rr.sat = 0;
    for (int i = 0; i < VDIM; i++) begin
      acc = 0;
      for (int j = 0; j < VDIM; j++) begin
        cf  = trans ? model_matrix[j*VDIM + i] : model_matrix[i*VDIM + j];
        p   = cf * v[j];
        dbl = strn ? (i >= 3 && j < 3) : (i < 3 && j >= 3);
        if (dbl) p = p * 2;
        acc = acc + p;
      end
      // arithmetic shift floors, giving round half toward plus infinity
      q = (acc + 64'sd524288) >>> RND_SHIFT;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647; rr.sat = 1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648; rr.sat = 1;
      end
      rr.res[32*i +: 32] = q[31:0];
    end
    expected_rotations.push_back(rr);
  endfunction

  function automatic logic [31:0] rand_vec(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return 32'($signed(18'($urandom)));
    endcase
  endfunction

  function automatic stim_t make_load(int r, int c, logic [23:0] val);
    stim_t it;
    it.op = OP_LOAD;
    it.data = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
    it.data[2:0] = 3'(r);
    it.data[5:3] = 3'(c);
    it.data[29:6] = val;
    it.data[223:222] = 2'b00;
    return it;
  endfunction

  function automatic stim_t make_rot(logic [2:0] op, int kind);
    stim_t it;
    it.op = op;
    it.data = '0;
    it.data[29:0] = 30'($urandom);
    for (int j = 0; j < VDIM; j++) it.data[30 + 32*j +: 32] = rand_vec(kind);
    return it;
  endfunction

  function automatic logic [23:0] rand_coef(int kind);
    case (kind)
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'($signed(22'($urandom)));
    endcase
  endfunction

  // Fill the item queue: directed part, then random matrices and rotations.
  initial begin
    stim_t it;
    int    kind;
    foreach (model_matrix[k]) model_matrix[k] = 0;
    // rotation with the all-zero reset matrix
    pending_items.push_back(make_rot(OP_STRAIN_FWD, 1));
    // full-scale coefficients on a few entries, plus out-of-range loads
    pending_items.push_back(make_load(0, 0, 24'h7fffff));
    pending_items.push_back(make_load(0, 4, 24'h800000));
    pending_items.push_back(make_load(4, 1, 24'h7fffff));
    pending_items.push_back(make_load(5, 5, 24'h800000));
    pending_items.push_back(make_load(2, 3, 24'h100000));
    pending_items.push_back(make_load(6, 0, 24'h7fffff));
    pending_items.push_back(make_load(1, 7, 24'h800000));
    pending_items.push_back(make_load(7, 6, 24'h123456));
    // every mode at extreme vectors: saturation in both directions
    for (int op = OP_STRAIN_FWD; op <= OP_STRAIN_BWD; op++) begin
      pending_items.push_back(make_rot(3'(op), 1));
      pending_items.push_back(make_rot(3'(op), 0));
    end
    // unknown ops are dropped
    for (int op = 5; op <= 7; op++) begin
      it = make_rot(3'(op), 0);
      pending_items.push_back(it);
    end
    pending_items.push_back(make_rot(OP_STRESS_FWD, 3));
    // random part: matrix reloads followed by bursts of rotations
    while (pending_items.size() < 1150) begin
      kind = $urandom_range(0, 2);
      for (int n = $urandom_range(1, 40); n > 0; n--)
        pending_items.push_back(make_load($urandom_range(0, 7), $urandom_range(0, 7),
                                          rand_coef(kind)));
      for (int n = $urandom_range(5, 40); n > 0; n--) begin
        if ($urandom_range(0, 19) == 0) begin
          it = make_rot(3'($urandom_range(5, 7)), 0);
          pending_items.push_back(it);
        end else
          pending_items.push_back(make_rot(3'($urandom_range(1, 4)),
                                           $urandom_range(0, 3)));
      end
    end
    stim_done = 1;
  end

  // Reset, then watch for completion or timeout.
  initial begin
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    wait (stim_done && pending_items.size() == 0 && !in_tvalid &&
          expected_rotations.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_rotations.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver: bursts of random length with random gaps; hold the item until
  // accepted, then advance on the falling edge.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  acc_seen = 0;

  always @(posedge clk) acc_seen <= in_tvalid && in_tready;

  initial begin
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (acc_seen || !in_tvalid) begin
        if (acc_seen) begin
          stim_t done_item;
          done_item = pending_items.pop_front();
          predict_rotation(done_item);
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 0;
        end else if (pending_items.size() > 0 && stim_done) begin
          in_tvalid <= 1;
          in_tdata <= pending_items[0].data;
          in_tuser <= pending_items[0].op;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else
            burst_left <= burst_left - 1;
        end else
          in_tvalid <= 0;
      end
    end
  end

  // Receiver: random stall pattern, clean stretches, and one long hold-off.
  int rx_phase = 0;
  int hold_count = 0;
  bit did_hold = 0;

  initial out_tready = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_phase <= (rx_phase + 1) % 512;
      if (!did_hold && pending_items.size() < 900 && pending_items.size() > 0
          && hold_count < 200) begin
        hold_count <= hold_count + 1;
        if (hold_count == 199) did_hold <= 1;
        out_tready <= 0;
      end else if (rx_phase < 128)
        out_tready <= 1;
      else
        out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rotations.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        fail_count = fail_count + 1;
      end else begin
        want = expected_rotations.pop_front();
        for (int i = 0; i < VDIM; i++)
          if (out_tdata[32*i +: 32] !== want.res[32*i +: 32]) begin
            $error("res component %0d: expected %h, actual %h", i,
                   want.res[32*i +: 32], out_tdata[32*i +: 32]);
            fail_count = fail_count + 1;
          end
        if (out_tuser[0] !== want.sat) begin
          $error("saturated: expected %b, actual %b", want.sat, out_tuser[0]);
          fail_count = fail_count + 1;
        end
      end
    end
  end

endmodule
